// File: rtl/core/psfd_pkg.sv
// ----------------------------------------------------------------------------
// psfd_pkg
// Types, constants and register codes shared by the fan drive PID block.
// ----------------------------------------------------------------------------
package psfd_pkg;

	// Register indexes of the configuration port.
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_KP_GAIN     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KI_GAIN     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KD_GAIN     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_FIRST  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BASE_SECOND = 3'd4;

	localparam int CFG_DATA_W = 16;

	// The proportional and derivative gains are kept pre-scaled, so the back end needs one multiply per term.
	localparam int KP_SCALED_W = 23;
	localparam int KD_SCALED_W = 26;
	localparam int KP_SCALE    = 100;
	localparam int KD_SCALE    = 1000;

	localparam logic [KP_SCALED_W-1:0] KP_SCALED_RESET = 23'd99000;
	localparam logic [15:0]            KI_GAIN_RESET   = 16'd23;
	localparam logic [KD_SCALED_W-1:0] KD_SCALED_RESET = 26'd7500000;
	localparam logic [15:0]            BASE_FIRST_RESET  = 16'd837;
	localparam logic [15:0]            BASE_SECOND_RESET = 16'd800;

	// Error and integral formats.
	localparam int ERR_W  = 17;
	localparam int SUM_W  = 23;
	localparam int DIFF_W = 18;
	localparam logic signed [17:0]    LEVEL_ANGLE = 18'sd9000;
	localparam logic signed [17:0]    ERR_MAX     = 18'sd65535;
	localparam logic signed [17:0]    ERR_MIN     = -18'sd65536;
	localparam logic signed [23:0]    SUM_LIMIT   = 24'sd4000000;

	// Controller sum and drive scaling.
	localparam int PSUM_W = 46;
	// Drives of 65536 or more saturate the driven compare, so they are flagged early.
	localparam logic [PSUM_W-1:0] DRIVE_SAT_LIMIT = 46'd65536000000;
	// floor(x / 15625) for x below 2**30 equals (x * RECIP) >> RECIP_SHIFT.
	localparam logic [30:0] RECIP       = 31'd1125899907;
	localparam int          RECIP_SHIFT = 44;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic signed [15:0] target_angle;
		logic signed [15:0] pitch_angle;
	} in_item_t;

	typedef struct packed {
		logic [15:0] compare_first;
		logic [15:0] compare_second;
	} out_item_t;

	// One classified sample waiting for the arithmetic.
	typedef struct packed {
		logic signed [ERR_W-1:0]  err;
		logic signed [SUM_W-1:0]  err_sum;
		logic signed [DIFF_W-1:0] err_diff;
	} work_t;

	typedef struct packed {
		logic [KP_SCALED_W-1:0] kp_scaled;
		logic [15:0]            ki_gain;
		logic [KD_SCALED_W-1:0] kd_scaled;
		logic [15:0]            base_first;
		logic [15:0]            base_second;
	} gains_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_status_t;

endpackage

// File: rtl/core/pid_split_fan_drive.sv
// ----------------------------------------------------------------------------
// pid_split_fan_drive
// Positional PID with a clamped integral that steers two fan PWM compares.
// An accepted sample waits in the queue, then passes stages s1 to s4 and the output register.
// Throughput: one sample per cycle while no result is held, through the five-stage arithmetic pipeline.
// A held result stalls the pipeline; the four-entry queue then absorbs input.
// Reset clears the integral, the last error and the queue, and loads gains.
// ----------------------------------------------------------------------------
module pid_split_fan_drive
	import psfd_pkg::*;
#(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_data
);

	gains_t    gains_q;
	q_status_t q_status;
	logic      push, pop;
	work_t     push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.kp_scaled   <= KP_SCALED_RESET;
			gains_q.ki_gain     <= KI_GAIN_RESET;
			gains_q.kd_scaled   <= KD_SCALED_RESET;
			gains_q.base_first  <= BASE_FIRST_RESET;
			gains_q.base_second <= BASE_SECOND_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_KP_GAIN:
					gains_q.kp_scaled <= KP_SCALED_W'(cfg_data) * KP_SCALED_W'(KP_SCALE);
				REG_KI_GAIN:     gains_q.ki_gain <= cfg_data;
				REG_KD_GAIN:
					gains_q.kd_scaled <= KD_SCALED_W'(cfg_data) * KD_SCALED_W'(KD_SCALE);
				REG_BASE_FIRST:  gains_q.base_first  <= cfg_data;
				REG_BASE_SECOND: gains_q.base_second <= cfg_data;
				default: ;
			endcase
		end
	end

	psfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	psfd_queue #(
		.DEPTH (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	psfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.gains      (gains_q),
		.q_data     (pop_data),
		.q_nonempty (q_status.nonempty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	// A held result must freeze the queue read side.
	a_hold_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> !pop)
		else $error("queue popped while a result was held");

	// The back end never reads an empty queue.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_status.nonempty)
		else $error("pop from an empty queue");

	// Only one fan is driven above its idle value.
	a_one_fan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.compare_first == gains_q.base_first ||
			out_data.compare_second == gains_q.base_second))
		else $error("both fan compares moved off their base values");

endmodule

// File: rtl/core/psfd_front.sv
// ----------------------------------------------------------------------------
// psfd_front
// Takes samples, forms the saturated error, the clamped integral and the
// derivative difference, and hands them to the queue.
// ----------------------------------------------------------------------------
module psfd_front
	import psfd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	input  q_status_t q_status,
	output logic      push,
	output work_t     push_data
);

	logic signed [ERR_W-1:0] err_sum_q_unused_guard;
	logic signed [SUM_W-1:0] err_sum_q;
	logic signed [ERR_W-1:0] prev_err_q;
	logic signed [17:0]      err_raw;
	logic signed [ERR_W-1:0] err_sat;
	logic signed [23:0]      sum_raw;
	logic signed [SUM_W-1:0] sum_clamped;

	assign in_stall = q_status.full;
	assign push     = in_valid && !q_status.full;

	always_comb begin
		err_raw = 18'(in_data.target_angle) + 18'(in_data.pitch_angle) - LEVEL_ANGLE;
		if (err_raw > ERR_MAX) begin
			err_sat = ERR_MAX[ERR_W-1:0];
		end else if (err_raw < ERR_MIN) begin
			err_sat = ERR_MIN[ERR_W-1:0];
		end else begin
			err_sat = err_raw[ERR_W-1:0];
		end
		sum_raw = 24'(err_sum_q) + 24'(err_sat);
		if (sum_raw > SUM_LIMIT) begin
			sum_clamped = SUM_LIMIT[SUM_W-1:0];
		end else if (sum_raw < -SUM_LIMIT) begin
			sum_clamped = 23'(-SUM_LIMIT);
		end else begin
			sum_clamped = sum_raw[SUM_W-1:0];
		end
	end

	assign err_sum_q_unused_guard = prev_err_q;

	always_comb begin
		push_data.err      = err_sat;
		push_data.err_sum  = sum_clamped;
		push_data.err_diff = DIFF_W'(err_sat) - DIFF_W'(err_sum_q_unused_guard);
	end

	// The loop state moves only when a sample is actually taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_sum_q  <= '0;
			prev_err_q <= '0;
		end else if (push) begin
			err_sum_q  <= sum_clamped;
			prev_err_q <= err_sat;
		end
	end

endmodule

// File: rtl/core/psfd_queue.sv
// ----------------------------------------------------------------------------
// psfd_queue
// Short first-in first-out queue of classified samples between the front and
// the arithmetic back end.
// ----------------------------------------------------------------------------
module psfd_queue
	import psfd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  work_t     push_data,
	input  logic      pop,
	output work_t     pop_data,
	output q_status_t status
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	work_t            entries_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full     = (count_q == CntW'(DEPTH));
	assign status.nonempty = (count_q != '0);
	assign do_push  = push && !status.full;
	assign do_pop   = pop && status.nonempty;
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/core/psfd_back.sv
// ----------------------------------------------------------------------------
// psfd_back
// Arithmetic pipeline: the three gain products, their sum, the magnitude,
// the division by one million and the saturated compare values.
// ----------------------------------------------------------------------------
module psfd_back
	import psfd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  gains_t    gains,
	input  work_t     q_data,
	input  logic      q_nonempty,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic                     adv;
	logic                     v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic signed [40:0]       prod_p_s1;
	logic signed [39:0]       prod_i_s1;
	logic signed [44:0]       prod_d_s1;
	logic signed [PSUM_W-1:0] psum_s2;
	logic                     pos_s3, big_s3;
	logic [29:0]              x_s3;
	logic                     pos_s4, big_s4;
	logic [60:0]              quot_s4;
	logic [PSUM_W-1:0]        mag;
	logic [15:0]              drive;
	logic [16:0]              first_sum, second_sum;
	out_item_t                out_data_q;

	// The whole pipeline holds while a result waits to be taken.
	assign adv       = !out_valid_q || !out_stall;
	assign pop       = adv && q_nonempty;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign mag = psum_s2[PSUM_W-1] ? PSUM_W'(-psum_s2) : PSUM_W'(psum_s2);

	always_comb begin
		drive = big_s4 ? 16'hFFFF : quot_s4[RECIP_SHIFT+15:RECIP_SHIFT];
		first_sum  = {1'b0, gains.base_first} + {1'b0, drive};
		second_sum = {1'b0, gains.base_second} + {1'b0, drive};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= q_nonempty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_p_s1 <= $signed({1'b0, gains.kp_scaled}) * q_data.err;
			prod_i_s1 <= $signed({1'b0, gains.ki_gain}) * q_data.err_sum;
			prod_d_s1 <= $signed({1'b0, gains.kd_scaled}) * q_data.err_diff;

			psum_s2 <= PSUM_W'(prod_p_s1) + PSUM_W'(prod_i_s1) + PSUM_W'(prod_d_s1);

			pos_s3 <= !psum_s2[PSUM_W-1] && (psum_s2 != '0);
			big_s3 <= (mag >= DRIVE_SAT_LIMIT);
			// Dividing by 64 first leaves a division by 15625.
			x_s3   <= mag[35:6];

			pos_s4  <= pos_s3;
			big_s4  <= big_s3;
			quot_s4 <= {31'd0, x_s3} * {30'd0, RECIP};

			if (pos_s4) begin
				out_data_q.compare_first  <= first_sum[16] ? 16'hFFFF : first_sum[15:0];
				out_data_q.compare_second <= gains.base_second;
			end else begin
				out_data_q.compare_first  <= gains.base_first;
				out_data_q.compare_second <= second_sum[16] ? 16'hFFFF : second_sum[15:0];
			end
		end
	end

endmodule
